>>> hdl/mps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mps_pkg;

   // Field widths
   localparam int DATA_W      = 16;
   localparam int ADDR_W      = 32;
   localparam int PAT_W       = 32;
   localparam int CNT_W       = 16;
   localparam int LENREG_W    = 5;
   localparam int PIDX_W      = 4;
   localparam int MODE_W      = 2;
   localparam int KIND_W      = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_TDATA_W = 88;
   localparam int RSP_TDATA_W = 64;

   // Request kinds carried on tuser
   localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_START = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ELEM  = 2'd2;

   // Search kinds
   localparam logic [KIND_W-1:0] KIND_EXACT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REL8  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REL16 = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_KIND   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_END    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX    = 2'd3;

   // Control shared by every window cell
   typedef struct packed {
      logic shift;
      logic relative;
      logic wide;
   } cell_ctrl_type;

   // Result payload, address in the low bits
   typedef struct packed {
      logic [CNT_W-1:0]  match_number;
      logic [DATA_W-1:0] match_value;
      logic [ADDR_W-1:0] match_address;
   } rsp_type;

endpackage

`default_nettype wire

>>> hdl/mps_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module mps_cell (
   input  wire                      clock,
   input  mps_pkg::cell_ctrl_type   ctrl,
   input  wire  [mps_pkg::DATA_W-1:0] din,
   input  wire  [mps_pkg::PAT_W-1:0]  pat_in,
   input  wire  [mps_pkg::PAT_W-1:0]  pat_diff_in,
   output logic [mps_pkg::DATA_W-1:0] value,
   output logic                       hit
);
   import mps_pkg::*;

   logic [DATA_W-1:0] value_ff, value_in;
   logic [PAT_W-1:0]  pat_ff, pat_diff_ff;
   logic [DATA_W-1:0] mask, cur, own;
   logic [PAT_W-1:0]  diff;

   // window slot: takes din (the neighbor's value, or the new element at cell 0) on a shift
   always_comb begin
      value_in = ctrl.shift ? din : value_ff;
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      pat_ff      <= pat_in;
      pat_diff_ff <= pat_diff_in;
   end

   // match din low byte to pattern, or in relative mode din - value to step
   always_comb begin
      mask = ctrl.wide ? 16'hFFFF : 16'h00FF;
      cur  = din & mask;
      own  = value_ff & mask;
      diff = {16'b0, cur} - {16'b0, own};
      if (ctrl.relative) begin
         hit = (diff == pat_diff_ff);
      end else begin
         hit = (din[7:0] == pat_ff[7:0]);
      end
   end

   assign value = value_ff;

endmodule

`default_nettype wire

>>> hdl/mps_skid.sv
`timescale 1ns / 1ps
`default_nettype none

module mps_skid (
   input  wire               clock,
   input  wire               reset,
   input  wire               in_valid,
   input  mps_pkg::rsp_type  in_data,
   output logic              in_ready,
   output logic              out_valid,
   output mps_pkg::rsp_type  out_data,
   input  wire               out_ready
);
   import mps_pkg::*;

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_data_ff, out_data_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    out_free;

   // output register plus one spare entry
   always_comb begin
      out_free      = !out_valid_ff || out_ready;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            if (in_valid) begin
               out_data_in = in_data;
            end
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

`default_nettype wire

>>> hdl/memory_pattern_search_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Result path: a memory element that completes a match has its result registered in the skid
//   buffer's output register, or its spare entry when rsp stalls; loads and starts give no result.
// Throughput: one item per cycle while req_tready is high.
// Reset: registers return to kind 0, length 1, end 0xFFFFFFFF, limit 0xFFFF; the search is
//   cleared. The pattern store is not cleared and must be loaded before use.
module memory_pattern_search_top #(
   parameter int PATTERN_MAX = 16
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // transfer in: tdata = pattern_index, pattern_value, address, data_value
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire  [mps_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // tuser = mode
   input  wire  [mps_pkg::MODE_W-1:0]           req_tuser,
   // transfer out: tdata = match_address, match_value, match_number
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [mps_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // register writes
   input  wire                                  csr_we,
   input  wire  [mps_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire  [mps_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import mps_pkg::*;

   localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int LEN_W = $clog2(PATTERN_MAX + 1);

   // request fields
   logic [MODE_W-1:0] mode;
   logic [PIDX_W-1:0] pattern_index;
   logic [PAT_W-1:0]  pattern_value;
   logic [ADDR_W-1:0] address;
   logic [DATA_W-1:0] data_value;
   logic              req_acc;

   assign mode          = req_tuser;
   assign pattern_index = req_tdata[3:0];
   assign pattern_value = req_tdata[35:4];
   assign address       = req_tdata[67:36];
   assign data_value    = req_tdata[83:68];
   assign req_acc       = req_tvalid && req_tready;

   // configuration registers
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [ADDR_W-1:0] end_ff, end_in;
   logic [CNT_W-1:0]  max_ff, max_in;

   always_comb begin
      kind_in = kind_ff;
      len_in  = len_ff;
      end_in  = end_ff;
      max_in  = max_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_KIND:   kind_in = csr_wdata[KIND_W-1:0];
            REG_LENGTH: begin
               if (int'(csr_wdata[LENREG_W-1:0]) > PATTERN_MAX) begin
                  len_in = LEN_W'(PATTERN_MAX);
               end else begin
                  len_in = LEN_W'(csr_wdata[LENREG_W-1:0]);
               end
            end
            REG_END:    end_in = csr_wdata[ADDR_W-1:0];
            REG_MAX:    max_in = csr_wdata[CNT_W-1:0];
            default:    kind_in = kind_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_EXACT;
         len_ff  <= LEN_W'(1);
         end_ff  <= '1;
         max_ff  <= '1;
      end else begin
         kind_ff <= kind_in;
         len_ff  <= len_in;
         end_ff  <= end_in;
         max_ff  <= max_in;
      end
   end

   // pattern store, written by load transfers
   logic [PAT_W-1:0] pat_ff [PATTERN_MAX];
   logic [PAT_W-1:0] pat_in [PATTERN_MAX];

   always_comb begin
      pat_in = pat_ff;
      if (req_acc && mode == MODE_LOAD && int'(pattern_index) < PATTERN_MAX) begin
         pat_in[IDX_W'(pattern_index)] = pattern_value;
      end
   end

   always_ff @(posedge clock) begin
      pat_ff <= pat_in;
   end

   // pattern aligned to the window: slot j meets element len-1-j
   logic [PAT_W-1:0] aligned_in      [PATTERN_MAX];
   logic [PAT_W-1:0] aligned_diff_in [PATTERN_MAX];

   always_comb begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
         aligned_in[j] = '0;
         if (j < int'(len_in)) begin
            aligned_in[j] = pat_in[IDX_W'(int'(len_in) - 1 - j)];
         end
      end
      for (int j = 0; j < PATTERN_MAX; j++) begin
         if (j < PATTERN_MAX - 1) begin
            aligned_diff_in[j] = aligned_in[j] - aligned_in[j+1];
         end else begin
            aligned_diff_in[j] = '0;
         end
      end
   end

   // search state
   logic [LEN_W-1:0] fill_ff, fill_in, fill_new;
   logic [CNT_W-1:0] count_ff, count_in, count_next;
   logic             done_ff, done_in;

   logic              kind_ok, elem_go, limit, shift;
   logic              relative, wide;
   logic              over_end, rel_ready, rel_over, exact_ok, rel_ok, all_hit;
   logic              res_valid, res_ready;
   logic [ADDR_W-1:0] len_m1, span, start;
   logic [DATA_W-1:0] val_sel;
   rsp_type           res_data;
   cell_ctrl_type     cell_ctrl;

   logic [DATA_W-1:0]      din  [PATTERN_MAX];
   logic [DATA_W-1:0]      w    [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] cell_hit, active;

   assign relative = (kind_ff != KIND_EXACT);
   assign wide     = (kind_ff == KIND_REL16);
   assign kind_ok  = (kind_ff == KIND_EXACT) || (kind_ff == KIND_REL8) ||
                     (kind_ff == KIND_REL16);
   assign elem_go  = req_acc && mode == MODE_ELEM && !done_ff && kind_ok;
   assign limit    = (count_ff >= max_ff);
   assign shift    = elem_go && !limit;

   assign cell_ctrl.shift    = shift;
   assign cell_ctrl.relative = relative;
   assign cell_ctrl.wide     = wide;

   // row of window cells, newest element enters cell 0
   for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
      if (j == 0) begin : g_head
         assign din[j] = data_value;
      end else begin : g_link
         assign din[j] = w[j-1];
      end

      mps_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .din         (din[j]),
         .pat_in      (aligned_in[j]),
         .pat_diff_in (aligned_diff_in[j]),
         .value       (w[j]),
         .hit         (cell_hit[j])
      );

      assign active[j] = relative ? (j + 1 < int'(len_ff)) : (j < int'(len_ff));
   end

   assign all_hit = &(cell_hit | ~active);

   // match decision for the element in flight
   always_comb begin
      if (int'(fill_ff) < PATTERN_MAX) begin
         fill_new = fill_ff + LEN_W'(1);
      end else begin
         fill_new = fill_ff;
      end
      len_m1     = ADDR_W'(len_ff) - ADDR_W'(1);
      span       = wide ? {len_m1[ADDR_W-2:0], 1'b0} : len_m1;
      start      = address - span;
      over_end   = (address > end_ff);
      rel_ready  = (len_ff >= LEN_W'(2)) && (fill_new >= len_ff);
      rel_over   = rel_ready && (start > end_ff);
      exact_ok   = !over_end && (len_ff != '0) && (fill_new >= len_ff) && all_hit;
      rel_ok     = rel_ready && !rel_over && all_hit;
      res_valid  = shift && (relative ? rel_ok : exact_ok);
      count_next = count_ff + CNT_W'(1);
      val_sel    = din[IDX_W'(len_ff - LEN_W'(1))];
   end

   assign res_data.match_address = start;
   assign res_data.match_value   = wide ? val_sel : {8'b0, val_sel[7:0]};
   assign res_data.match_number  = count_next;

   // search state update
   always_comb begin
      fill_in  = fill_ff;
      count_in = count_ff;
      done_in  = done_ff;
      if (req_acc && mode == MODE_START) begin
         fill_in  = '0;
         count_in = '0;
         done_in  = 1'b0;
      end else if (elem_go) begin
         if (limit) begin
            done_in = 1'b1;
         end else begin
            fill_in = fill_new;
            if (relative ? rel_over : over_end) begin
               done_in = 1'b1;
            end
            if (res_valid) begin
               count_in = count_next;
               if (count_next >= max_ff) begin
                  done_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         fill_ff  <= fill_in;
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   // result register with spare entry
   rsp_type rsp_data;

   mps_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res_data),
      .in_ready  (res_ready),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_data),
      .out_ready (rsp_tready)
   );

   assign req_tready = res_ready;
   assign rsp_tdata  = rsp_data;

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      int'(fill_ff) <= PATTERN_MAX)
      else $error("window fill beyond pattern depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      res_valid |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("match count did not advance with a result");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      done_ff && !(req_acc && mode == MODE_START) |=> done_ff)
      else $error("search resumed without a start");

   a_no_result_done: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !res_valid)
      else $error("result produced after search finished");
`endif

endmodule

`default_nettype wire
